>>> design/ubx_nmea_frame_splitter_top_assert.svh
// ----------------------------------------------------------------------------
// ubx_nmea_frame_splitter_top_assert.svh
// assertion macros for the frame splitter, clocked on clk, idle in reset
// ----------------------------------------------------------------------------
`ifndef UBX_NMEA_FRAME_SPLITTER_TOP_ASSERT_SVH
`define UBX_NMEA_FRAME_SPLITTER_TOP_ASSERT_SVH

// same-cycle implication
`define UBX_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define UBX_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/ubx_pkg.sv
// ----------------------------------------------------------------------------
// ubx_pkg
// shared constants and the result type of the ubx / nmea frame splitter
// ----------------------------------------------------------------------------
`default_nettype none

package ubx_pkg;

	localparam int BUF_DEPTH      = 256;
	localparam int OFS_W          = $clog2(BUF_DEPTH);
	localparam int LEN_W          = 16;
	localparam int CMP_W          = LEN_W + 1;
	localparam int FRAME_OVERHEAD = 8;
	localparam int LEN_LO_OFS     = 4;
	localparam int LEN_HI_OFS     = 5;

	localparam logic [7:0] SYNC_BYTE    = 8'hB5;
	localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

	typedef struct packed {
		logic [7:0]       data_byte;
		logic [7:0]       position;
		logic             is_binary;
		logic             frame_end;
		logic             wrapped;
		logic [LEN_W-1:0] payload_length;
	} result_t;

endpackage

`default_nettype wire

>>> design/ubx_nmea_frame_splitter_top.sv
// ----------------------------------------------------------------------------
// ubx_nmea_frame_splitter_top
// splits a received byte stream into binary packets and text lines
//
//   channel   signals                                         dir
//   input     in_valid, in_ready, rx_byte                     in
//   output    out_valid, out_ready, data_byte, position,      out
//             is_binary, frame_end, wrapped, payload_length
//
// one byte per cycle while in_ready is high; each result is registered when its request is taken
// the frame state updates in the same cycle the request is taken
// reset clears the frame offset, frame type and gathered length
// a skid entry lets one more request in while a result is stalled;
// in_ready drops only when both result entries are full
// ----------------------------------------------------------------------------
`default_nettype none

`include "ubx_nmea_frame_splitter_top_assert.svh"

module ubx_nmea_frame_splitter_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  rx_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       data_byte,
	output logic [7:0]       position,
	output logic             is_binary,
	output logic             frame_end,
	output logic             wrapped,
	output logic [15:0]      payload_length
);
	import ubx_pkg::*;

	logic    accept;
	result_t cur_res;
	result_t out_res;

	assign accept = in_valid && in_ready;

	ubx_frame_track u_track (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.rx_byte (rx_byte),
		.res     (cur_res)
	);

	ubx_out_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_res  (cur_res),
		.can_push  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (out_res)
	);

	assign data_byte      = out_res.data_byte;
	assign position       = out_res.position;
	assign is_binary      = out_res.is_binary;
	assign frame_end      = out_res.frame_end;
	assign wrapped        = out_res.wrapped;
	assign payload_length = out_res.payload_length;

	`UBX_ASSERT_NOW(a_full_has_result, !in_ready, out_valid,
		"skid entry full without a pending result")
	`UBX_ASSERT_NOW(a_line_end_zero, out_valid && frame_end && !is_binary,
		data_byte == 8'h00, "text line end not delivered as zero")
	`UBX_ASSERT_NOW(a_wrap_at_depth, out_valid && wrapped,
		position == 8'(BUF_DEPTH - 1), "wrap flagged away from last buffer slot")
	`UBX_ASSERT_NEXT(a_stall_blocks, !in_ready && !out_ready, !in_ready,
		"skid entry lost while output stalled")

endmodule

`default_nettype wire

>>> design/ubx_frame_track.sv
// ----------------------------------------------------------------------------
// ubx_frame_track
// frame state (offset, type, length) and per-byte result logic
// ----------------------------------------------------------------------------
`default_nettype none

module ubx_frame_track (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             accept,
	input  wire logic [7:0]       rx_byte,
	output ubx_pkg::result_t      res
);
	import ubx_pkg::*;

	logic [OFS_W-1:0] frame_offset_q;
	logic             binary_mode_q;
	logic [LEN_W-1:0] packet_length_q;

	logic [OFS_W-1:0] nxt_offset;
	logic [OFS_W:0]   inc_offset;
	logic             bin_mode;
	logic [LEN_W-1:0] pkt_len;
	logic             wrap;
	logic             fend;
	logic [7:0]       data_out;
	logic [OFS_W-1:0] after_wrap;

	always_comb begin
		bin_mode = binary_mode_q;
		pkt_len  = packet_length_q;
		if (frame_offset_q == '0) begin
			bin_mode = (rx_byte == SYNC_BYTE);
			pkt_len  = '0;
		end
		if (bin_mode && frame_offset_q == OFS_W'(LEN_LO_OFS)) begin
			pkt_len = LEN_W'(rx_byte);
		end
		if (bin_mode && frame_offset_q == OFS_W'(LEN_HI_OFS)) begin
			pkt_len = pkt_len | {rx_byte, 8'h00};
		end

		inc_offset = {1'b0, frame_offset_q} + (OFS_W+1)'(1);
		wrap       = inc_offset > (OFS_W+1)'(BUF_DEPTH - 1);
		after_wrap = wrap ? '0 : inc_offset[OFS_W-1:0];

		data_out   = rx_byte;
		fend       = 1'b0;
		nxt_offset = after_wrap;
		if (!bin_mode && rx_byte == NEWLINE_BYTE) begin
			data_out   = 8'h00;
			fend       = 1'b1;
			nxt_offset = '0;
		end else if (bin_mode && CMP_W'(after_wrap) ==
				({1'b0, pkt_len} + CMP_W'(FRAME_OVERHEAD))) begin
			fend       = 1'b1;
			nxt_offset = '0;
		end

		res.data_byte      = data_out;
		res.position       = 8'(frame_offset_q);
		res.is_binary      = bin_mode;
		res.frame_end      = fend;
		res.wrapped        = wrap;
		res.payload_length = pkt_len;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_offset_q  <= '0;
			binary_mode_q   <= 1'b0;
			packet_length_q <= '0;
		end else if (accept) begin
			frame_offset_q  <= nxt_offset;
			binary_mode_q   <= bin_mode;
			packet_length_q <= pkt_len;
		end
	end

endmodule

`default_nettype wire

>>> design/ubx_out_skid.sv
// ----------------------------------------------------------------------------
// ubx_out_skid
// result register with a skid entry, decoupling input ready from output ready
// ----------------------------------------------------------------------------
`default_nettype none

module ubx_out_skid (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire ubx_pkg::result_t push_res,
	output logic                  can_push,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output ubx_pkg::result_t      out_res
);
	import ubx_pkg::*;

	logic    main_valid_q;
	logic    skid_valid_q;
	result_t main_q;
	result_t skid_q;
	logic    pop;

	assign pop       = main_valid_q && out_ready;
	assign can_push  = !skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_res   = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				main_valid_q <= push;
			end
		end else if (push) begin
			if (main_valid_q) begin
				skid_valid_q <= 1'b1;
			end else begin
				main_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q) begin
				main_q <= skid_q;
			end else if (push) begin
				main_q <= push_res;
			end
		end else if (push) begin
			if (main_valid_q) begin
				skid_q <= push_res;
			end else begin
				main_q <= push_res;
			end
		end
	end

endmodule

`default_nettype wire
